// ===== src/seqd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// seqd_pkg: shared types and constants
// widths, register indexes and the front-to-back command beat
// ---------------------------------------------------------------------------
package seqd_pkg;
    localparam int MAX_SERVERS = 8;
    localparam int FIFO_DEPTH  = 16;
    localparam int SRV_W       = $clog2(MAX_SERVERS);
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int MEM_DEPTH   = MAX_SERVERS * FIFO_DEPTH;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int JOB_W       = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DAT_W   = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SERVER_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_MASK    = 8'd1;

    typedef struct packed {
        logic             req_type;
        logic [JOB_W-1:0] job_id;
        logic             job_kind;
        logic [2:0]       server_index;
    } t_cmd;
endpackage

// ===== src/shortest_eligible_queue_dispatch_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shortest_eligible_queue_dispatch_unit: join-shortest-queue dispatcher
// An arrival runs the engine through the load scan, which visits one server
// per cycle (capped at 8 servers), then the dispatch step; a completion runs
// through the registered job ram read. A two-beat command queue and the
// result register let input and output stall apart.
// ---------------------------------------------------------------------------
module shortest_eligible_queue_dispatch_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [15:0] i_job_id,
    input  logic        i_job_kind,
    input  logic [2:0]  i_server_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_chosen_server,
    output logic        o_started_service,
    output logic [15:0] o_started_job_id,
    output logic        o_server_now_idle,
    output logic [4:0]  o_queue_length,
    output logic [7:0]  o_jobs_present,
    output logic        o_no_eligible,
    output logic        o_overflow
);
    seqd_pkg::t_cmd w_in, w_q;
    logic w_qv, w_qr;
    logic [3:0] r_server_count;
    logic [7:0] r_type_mask;

    assign w_in = '{req_type: i_req_type, job_id: i_job_id,
                    job_kind: i_job_kind, server_index: i_server_index};
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_count <= 4'd4;
            r_type_mask    <= 8'd0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == seqd_pkg::REG_SERVER_COUNT)
                r_server_count <= i_cfg_data[3:0];
            else if (i_cfg_index == seqd_pkg::REG_TYPE_MASK)
                r_type_mask <= i_cfg_data;
        end
    end

    seqd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_cmd(w_in), .o_valid(w_qv), .i_ready(w_qr), .o_cmd(w_q)
    );

    seqd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .o_ready(w_qr),
        .i_cmd(w_q), .i_server_count(r_server_count), .i_type_mask(r_type_mask),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_chosen_server(o_chosen_server), .o_started_service(o_started_service),
        .o_started_job_id(o_started_job_id), .o_server_now_idle(o_server_now_idle),
        .o_queue_length(o_queue_length), .o_jobs_present(o_jobs_present),
        .o_no_eligible(o_no_eligible), .o_overflow(o_overflow)
    );
endmodule

// ===== src/seqd_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// seqd_ram: generic single-port ram
// one write or read per cycle, registered read data
// ---------------------------------------------------------------------------
module seqd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== src/seqd_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// seqd_front: input stage and command queue
// takes request beats into a two-entry queue toward the back end
// ---------------------------------------------------------------------------
module seqd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  seqd_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output seqd_pkg::t_cmd o_cmd
);
    seqd_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ===== src/seqd_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// seqd_back: dispatch engine
// scans server loads one per cycle, updates fifo state and job ram
// ---------------------------------------------------------------------------
module seqd_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  seqd_pkg::t_cmd                   i_cmd,
    input  logic [3:0]                       i_server_count,
    input  logic [7:0]                       i_type_mask,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [2:0]                       o_chosen_server,
    output logic                             o_started_service,
    output logic [15:0]                      o_started_job_id,
    output logic                             o_server_now_idle,
    output logic [4:0]                       o_queue_length,
    output logic [7:0]                       o_jobs_present,
    output logic                             o_no_eligible,
    output logic                             o_overflow
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DISP = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_DATA = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam int SW = seqd_pkg::SRV_W;
    localparam int CW = seqd_pkg::CNT_W;
    localparam int PW = seqd_pkg::PTR_W;

    logic [2:0]  r_st;
    seqd_pkg::t_cmd r_cmd;
    logic [seqd_pkg::MAX_SERVERS-1:0] r_busy;
    logic [PW-1:0] r_head [seqd_pkg::MAX_SERVERS];
    logic [CW-1:0] r_cnt  [seqd_pkg::MAX_SERVERS];
    logic [7:0]  r_present;
    logic [SW:0] r_i, r_limit;
    logic        r_found;
    logic [SW-1:0] r_best;
    logic [CW:0] r_best_load;
    logic        r_ov, r_st_svc, r_idle, r_noel, r_ovf;
    logic [2:0]  r_srv;
    logic [15:0] r_jid;
    logic [4:0]  r_ql;
    logic        r_o_st_svc, r_o_idle, r_o_noel, r_o_ovf;
    logic [2:0]  r_o_srv;
    logic [15:0] r_o_jid;
    logic [4:0]  r_o_ql;
    logic [7:0]  r_o_present;
    logic        w_out_load;
    logic        w_we;
    logic [seqd_pkg::MEM_AW-1:0] w_addr;
    logic [15:0] w_rdata;
    logic [CW:0] w_load;
    logic [SW-1:0] w_i;
    logic [SW-1:0] w_cs;
    logic [PW-1:0] w_slot;

    assign w_i    = r_i[SW-1:0];
    assign w_load = {{CW{1'b0}}, r_busy[w_i]} + {1'b0, r_cnt[w_i]};
    assign w_cs   = r_cmd.server_index[SW-1:0];
    assign w_slot = PW'(r_head[r_best] + r_cnt[r_best][PW-1:0]);
    assign w_we   = (r_st == ST_DISP) && r_found && r_busy[r_best]
                    && (r_cnt[r_best] < CW'(seqd_pkg::FIFO_DEPTH));
    always_comb begin
        if (r_st == ST_DISP) w_addr = {r_best, w_slot};
        else                 w_addr = {w_cs, r_head[w_cs]};
    end

    seqd_ram #(.WIDTH(16), .DEPTH(seqd_pkg::MEM_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(r_cmd.job_id), .o_rdata(w_rdata)
    );

    assign w_out_load = (r_st == ST_OUT) && (!r_ov || i_ready);

    assign o_ready = (r_st == ST_IDLE);
    assign o_valid = r_ov;
    assign o_chosen_server   = r_o_srv;
    assign o_started_service = r_o_st_svc;
    assign o_started_job_id  = r_o_jid;
    assign o_server_now_idle = r_o_idle;
    assign o_queue_length    = r_o_ql;
    assign o_jobs_present    = r_o_present;
    assign o_no_eligible     = r_o_noel;
    assign o_overflow        = r_o_ovf;

    // result beat register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_srv     <= r_srv;
            r_o_st_svc  <= r_st_svc;
            r_o_jid     <= r_jid;
            r_o_idle    <= r_idle;
            r_o_ql      <= r_ql;
            r_o_present <= r_present;
            r_o_noel    <= r_noel;
            r_o_ovf     <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_IDLE;
            r_busy    <= '0;
            r_present <= '0;
            r_ov      <= 1'b0;
            for (int k = 0; k < seqd_pkg::MAX_SERVERS; k++) begin
                r_head[k] <= '0;
                r_cnt[k]  <= '0;
            end
        end else begin
            if (w_out_load)   r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= i_cmd;
                        r_i     <= '0;
                        r_found <= 1'b0;
                        r_limit <= (i_server_count > 4'(seqd_pkg::MAX_SERVERS))
                                   ? (SW+1)'(seqd_pkg::MAX_SERVERS)
                                   : (SW+1)'(i_server_count);
                        r_st    <= i_cmd.req_type ? ST_READ : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_i >= r_limit) begin
                        r_st <= ST_DISP;
                    end else begin
                        if ((i_type_mask[w_i] == r_cmd.job_kind)
                            && (!r_found || w_load < r_best_load)) begin
                            r_found     <= 1'b1;
                            r_best      <= w_i;
                            r_best_load <= w_load;
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                ST_DISP: begin
                    r_st_svc <= 1'b0; r_jid <= '0; r_idle <= 1'b0;
                    r_noel <= 1'b0; r_ovf <= 1'b0;
                    r_srv <= 3'(r_best); r_ql <= 5'(r_cnt[r_best]);
                    if (!r_found) begin
                        r_noel <= 1'b1; r_srv <= '0; r_ql <= '0;
                    end else if (!r_busy[r_best]) begin
                        r_busy[r_best] <= 1'b1;
                        r_st_svc <= 1'b1; r_jid <= r_cmd.job_id;
                        if (r_present != 8'hff) r_present <= r_present + 1'b1;
                    end else if (!w_we) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_cnt[r_best] <= r_cnt[r_best] + 1'b1;
                        r_ql <= 5'(r_cnt[r_best] + 1'b1);
                        if (r_present != 8'hff) r_present <= r_present + 1'b1;
                    end
                    r_st <= ST_OUT;
                end
                ST_READ: r_st <= ST_DATA;
                ST_DATA: begin
                    r_srv <= r_cmd.server_index; r_st_svc <= 1'b0; r_jid <= '0;
                    r_idle <= 1'b1; r_ql <= '0; r_noel <= 1'b0; r_ovf <= 1'b0;
                    if (r_busy[w_cs]) begin
                        if (r_present != 8'd0) r_present <= r_present - 1'b1;
                        if (r_cnt[w_cs] != '0) begin
                            r_head[w_cs] <= r_head[w_cs] + 1'b1;
                            r_cnt[w_cs]  <= r_cnt[w_cs] - 1'b1;
                            r_ql <= 5'(r_cnt[w_cs] - 1'b1);
                            r_st_svc <= 1'b1; r_jid <= w_rdata; r_idle <= 1'b0;
                        end else begin
                            r_busy[w_cs] <= 1'b0;
                        end
                    end else begin
                        r_ql <= 5'(r_cnt[w_cs]);
                    end
                    r_st <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_load) begin
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== src/seqd_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// seqd_checker: port-level checks
// result flag consistency and output handshake
// ---------------------------------------------------------------------------
module seqd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_started_service,
    input logic [15:0] o_started_job_id,
    input logic        o_server_now_idle,
    input logic        o_no_eligible,
    input logic        o_overflow,
    input logic [4:0]  o_queue_length
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_started_job_id))
        else $error("result beat changed while stalled");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_started_service, o_server_now_idle,
                                o_no_eligible, o_overflow}) <= 1)
        else $error("conflicting result flags");
    a_noel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_eligible |-> o_queue_length == 5'd0 && o_started_job_id == 16'd0)
        else $error("no_eligible with nonzero fields");
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_queue_length == 5'd16)
        else $error("overflow without full fifo");
endmodule

bind shortest_eligible_queue_dispatch_unit seqd_checker u_seqd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_started_service(o_started_service), .o_started_job_id(o_started_job_id),
    .o_server_now_idle(o_server_now_idle), .o_no_eligible(o_no_eligible),
    .o_overflow(o_overflow), .o_queue_length(o_queue_length)
);

// ===== sim/tb_shortest_eligible_queue_dispatch_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_shortest_eligible_queue_dispatch_unit: self-checking bench for the dispatcher
// A directed part and random phases under several register settings. Each
// accepted command goes through a local model of server loads and fifos, and
// every result beat is checked against the oldest predicted beat.
// ---------------------------------------------------------------------------
module tb_shortest_eligible_queue_dispatch_unit;
    typedef struct packed {
        logic [2:0]  server;
        logic        started;
        logic [15:0] started_id;
        logic        now_idle;
        logic [4:0]  qlen;
        logic [7:0]  present;
        logic        no_elig;
        logic        ovf;
    } t_dispatch;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_req_type = 1'b0;
    logic [15:0] i_job_id = '0;
    logic        i_job_kind = 1'b0;
    logic [2:0]  i_server_index = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_chosen_server;
    logic        o_started_service;
    logic [15:0] o_started_job_id;
    logic        o_server_now_idle;
    logic [4:0]  o_queue_length;
    logic [7:0]  o_jobs_present;
    logic        o_no_eligible;
    logic        o_overflow;

    shortest_eligible_queue_dispatch_unit i_dut (.*);

    // model state
    logic [3:0]  act_count = 4'd4;
    logic [7:0]  kind_mask = 8'd0;
    logic        busy [seqd_pkg::MAX_SERVERS];
    logic [15:0] waiting [seqd_pkg::MAX_SERVERS][seqd_pkg::FIFO_DEPTH];
    int          head [seqd_pkg::MAX_SERVERS];
    int          depth [seqd_pkg::MAX_SERVERS];
    int          present = 0;

    seqd_pkg::t_cmd pending_cmds[$];
    t_dispatch   expected_beats[$];
    bit          cmd_taken = 1'b0;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          hold_cycles = 0;
    int          errors = 0;
    int          cycle_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_dispatch dispatch_step(seqd_pkg::t_cmd c);
        t_dispatch r;
        int limit, best, best_load, load, s, slot;
        bit found;
        r = '0;
        if (!c.req_type) begin
            limit = (act_count < seqd_pkg::MAX_SERVERS) ? act_count : seqd_pkg::MAX_SERVERS;
            found = 0;
            best = 0;
            best_load = 0;
            for (int i = 0; i < limit; i++) begin
                if (kind_mask[i] != c.job_kind) continue;
                load = busy[i] + depth[i];
                if (!found || load < best_load) begin
                    found = 1;
                    best = i;
                    best_load = load;
                end
            end
            if (!found) begin
                r.no_elig = 1'b1;
            end else if (!busy[best]) begin
                busy[best] = 1'b1;
                if (present < 255) present++;
                r.server = 3'(best);
                r.started = 1'b1;
                r.started_id = c.job_id;
                r.qlen = 5'(depth[best]);
            end else if (depth[best] >= seqd_pkg::FIFO_DEPTH) begin
                r.server = 3'(best);
                r.qlen = 5'(depth[best]);
                r.ovf = 1'b1;
            end else begin
                slot = (head[best] + depth[best]) % seqd_pkg::FIFO_DEPTH;
                waiting[best][slot] = c.job_id;
                depth[best]++;
                if (present < 255) present++;
                r.server = 3'(best);
                r.qlen = 5'(depth[best]);
            end
        end else begin
            s = c.server_index;
            r.server = c.server_index;
            if (!busy[s]) begin
                r.now_idle = 1'b1;
                r.qlen = 5'(depth[s]);
            end else begin
                if (present > 0) present--;
                if (depth[s] > 0) begin
                    r.started = 1'b1;
                    r.started_id = waiting[s][head[s]];
                    head[s] = (head[s] + 1) % seqd_pkg::FIFO_DEPTH;
                    depth[s]--;
                    r.qlen = 5'(depth[s]);
                end else begin
                    busy[s] = 1'b0;
                    r.now_idle = 1'b1;
                end
            end
        end
        r.present = 8'(present);
        return r;
    endfunction

    function automatic seqd_pkg::t_cmd make_cmd(bit req, logic [15:0] id, bit kind,
                                                 logic [2:0] srv);
        seqd_pkg::t_cmd c;
        c.req_type = req;
        c.job_id = id;
        c.job_kind = kind;
        c.server_index = srv;
        return c;
    endfunction

    // sender
    always @(negedge i_clk) begin
        if (!i_valid || cmd_taken) begin
            cmd_taken = 1'b0;
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                seqd_pkg::t_cmd c;
                c = pending_cmds.pop_front();
                i_valid <= 1'b1;
                i_req_type <= c.req_type;
                i_job_id <= c.job_id;
                i_job_kind <= c.job_kind;
                i_server_index <= c.server_index;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver, with its own long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // accepted commands and result beats
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            expected_beats.push_back(dispatch_step(make_cmd(i_req_type, i_job_id,
                                                            i_job_kind, i_server_index)));
            cmd_taken = 1'b1;
        end
        if (i_rst_n && o_valid && i_ready) begin
            t_dispatch got, want;
            got = '{o_chosen_server, o_started_service, o_started_job_id,
                    o_server_now_idle, o_queue_length, o_jobs_present,
                    o_no_eligible, o_overflow};
            if (expected_beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, actual %p", $time, got);
            end else begin
                want = expected_beats.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch, expected %p actual %p", $time, want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 600000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [7:0] data);
        bit done;
        done = 0;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        while (!done) begin
            @(posedge i_clk);
            if (o_cfg_ready) begin
                done = 1;
                if (idx == seqd_pkg::REG_SERVER_COUNT) act_count = data[3:0];
                else if (idx == seqd_pkg::REG_TYPE_MASK) kind_mask = data;
            end
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        wait (pending_cmds.size() == 0 && !i_valid && expected_beats.size() == 0);
        repeat (30) @(posedge i_clk);
    endtask

    logic [3:0] phase_count [8] = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd8, 4'd3, 4'd6, 4'd2};
    logic [7:0] phase_mask  [8] = '{8'h55, 8'hff, 8'ha3, 8'h00, 8'hff, 8'h05, 8'h3c, 8'h02};

    initial begin
        for (int i = 0; i < seqd_pkg::MAX_SERVERS; i++) begin
            busy[i] = 1'b0;
            head[i] = 0;
            depth[i] = 0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one server, kind zero only
        write_reg(seqd_pkg::REG_SERVER_COUNT, 8'd1);
        write_reg(seqd_pkg::REG_TYPE_MASK, 8'h00);
        pending_cmds.push_back(make_cmd(1'b0, 16'h0000, 1'b1, 3'd0));
        pending_cmds.push_back(make_cmd(1'b1, 16'h0000, 1'b0, 3'd0));
        pending_cmds.push_back(make_cmd(1'b0, 16'hffff, 1'b0, 3'd7));
        for (int i = 0; i < 17; i++)
            pending_cmds.push_back(make_cmd(1'b0, 16'(i * 16'h0f0f), 1'b0, 3'd0));
        pending_cmds.push_back(make_cmd(1'b1, 16'hffff, 1'b1, 3'd5));
        pending_cmds.push_back(make_cmd(1'b1, 16'h0000, 1'b0, 3'd0));
        pending_cmds.push_back(make_cmd(1'b1, 16'h0000, 1'b0, 3'd7));
        drain();

        for (int p = 0; p < 8; p++) begin
            if (p < 3) begin
                send_idle = 27;
                recv_idle = 60;
            end else if (p < 6) begin
                send_idle = 60;
                recv_idle = 27;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_reg(seqd_pkg::REG_SERVER_COUNT, (p == 7) ? 8'hf7 : 8'(phase_count[p]));
            write_reg(seqd_pkg::REG_TYPE_MASK, phase_mask[p]);
            if (p == 6) hold_cycles = 400;
            for (int n = 0; n < 190; n++)
                pending_cmds.push_back(make_cmd($urandom_range(0, 99) < 55 ? 1'b0 : 1'b1,
                                                16'($urandom), 1'($urandom),
                                                3'($urandom_range(0, 7))));
            drain();
        end

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
